/* hw/rtl/rph_pkg.sv */
// ----------------------------------------------------------------------------
// Ratio percent histogram package
// Shared types and constants for the percentage histogram block.
// ----------------------------------------------------------------------------
package rph_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COUNT_W   = 32;
  localparam int BIN_W     = 7;
  localparam int NUM_BINS  = 102;
  localparam int OVF_BIN   = 101;
  localparam int PCT_SCALE = 100;
  localparam int NUM_W     = SAMPLE_W + BIN_W;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 operation;
    logic [SAMPLE_W-1:0] variant_count;
    logic [SAMPLE_W-1:0] read_depth;
    logic [BIN_W-1:0]    bin_select;
  } request_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_count;
  } result_t;

  typedef struct packed {
    op_e              op;
    logic [BIN_W-1:0] bin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_DIV,
    FR_PUSH
  } fr_state_e;

  typedef enum logic {
    BK_IDLE,
    BK_UPD
  } bk_state_e;

endpackage

/* hw/rtl/ratio_percent_histogram.sv */
// ----------------------------------------------------------------------------
// Ratio percent histogram
// Bins each record by floor(variant_count*100/read_depth), with zero depth
// and ratios above 100 going to bin 101, and reads back single bins.
// ----------------------------------------------------------------------------
// Path: an accumulate passes FR_MUL, the 8-step iterative divider in FR_DIV
// and FR_PUSH; a read goes straight to FR_PUSH, which waits on a full queue.
// The front end takes a new transaction once it has pushed its job; the back
// end pops jobs in BK_IDLE and strobes each result from BK_UPD.
// Reset clears all bins through per-bin valid flags.
// Results cannot be stalled; each strobe lasts exactly one cycle.
module ratio_percent_histogram (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rph_pkg::request_t  request,
  output logic               busy,
  output logic               done,
  output rph_pkg::result_t   result
);
  import rph_pkg::*;

  q_status_t q_status;
  logic      push;
  job_t      push_item;
  logic      pop;
  job_t      pop_item;

  rph_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  rph_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  rph_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop      (pop),
    .pop_item (pop_item),
    .done     (done),
    .result   (result)
  );

endmodule

/* hw/rtl/rph_front.sv */
// ----------------------------------------------------------------------------
// Ratio percent histogram front end
// Accepts transactions and turns each record into a bin number with an
// iterative restoring divider, then hands the job to the queue.
// ----------------------------------------------------------------------------
module rph_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rph_pkg::request_t   request,
  output logic                busy,
  input  rph_pkg::q_status_t  q_status,
  output logic                push,
  output rph_pkg::job_t       push_item
);
  import rph_pkg::*;

  fr_state_e            state;
  fr_state_e            state_next;
  op_e                  op;
  logic [BIN_W-1:0]     sel;
  logic [SAMPLE_W-1:0]  count;
  logic [SAMPLE_W-1:0]  depth;
  logic [NUM_W-1:0]     rem;
  logic [BIN_W:0]       quot;
  logic [2:0]           step;
  logic [NUM_W-1:0]     shifted;
  logic                 accept;
  logic [BIN_W-1:0]     bin;

  assign accept  = start && (state == FR_IDLE);
  assign shifted = NUM_W'(depth) << step;

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (accept) begin
          state_next = (request.operation == OP_READ) ? FR_PUSH : FR_MUL;
        end
      end
      FR_MUL:  state_next = FR_DIV;
      FR_DIV: begin
        if (step == 3'd0) begin
          state_next = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_status.full) begin
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    if (op == OP_READ) begin
      bin = sel;
    end else if (quot > (BIN_W+1)'(PCT_SCALE)) begin
      bin = BIN_W'(OVF_BIN);
    end else begin
      bin = quot[BIN_W-1:0];
    end
  end

  always_comb begin
    busy         = (state != FR_IDLE);
    push         = (state == FR_PUSH) && !q_status.full;
    push_item.op  = op;
    push_item.bin = bin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= request.operation;
      sel   <= request.bin_select;
      count <= request.variant_count;
      depth <= request.read_depth;
    end
    if (state == FR_MUL) begin
      rem  <= NUM_W'(count) * NUM_W'(PCT_SCALE);
      quot <= '0;
      step <= 3'd7;
    end
    if (state == FR_DIV) begin
      if (rem >= shifted) begin
        rem        <= rem - shifted;
        quot[step] <= 1'b1;
      end
      step <= step - 3'd1;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != FR_IDLE))
    else $error("front stayed idle after accepting a transaction");

  a_bin_in_range: assert property (@(posedge clk) disable iff (rst)
    (push && (push_item.op == OP_ACCUM)) |-> (push_item.bin <= BIN_W'(OVF_BIN)))
    else $error("accumulate job carries a bin beyond the overflow bin");

endmodule

/* hw/rtl/rph_queue.sv */
// ----------------------------------------------------------------------------
// Ratio percent histogram job queue
// Two-entry FIFO between the front end and the histogram back end.
// ----------------------------------------------------------------------------
module rph_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rph_pkg::job_t       push_item,
  input  logic                pop,
  output rph_pkg::job_t       pop_item,
  output rph_pkg::q_status_t  q_status
);
  import rph_pkg::*;

  job_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  fill;

  assign pop_item       = entries[rd_ptr];
  assign q_status.full  = (fill == Q_CNT_W'(Q_DEPTH));
  assign q_status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (!q_status.full || pop))
    else $error("job queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("job queue read while empty");

endmodule

/* hw/rtl/rph_back.sv */
// ----------------------------------------------------------------------------
// Ratio percent histogram back end
// Holds the bin counters, performs the saturating increment or the bin
// read for each job and drives the result strobe.
// ----------------------------------------------------------------------------
module rph_back (
  input  logic                clk,
  input  logic                rst,
  input  rph_pkg::q_status_t  q_status,
  output logic                pop,
  input  rph_pkg::job_t       pop_item,
  output logic                done,
  output rph_pkg::result_t    result
);
  import rph_pkg::*;

  localparam logic [COUNT_W-1:0] CountMax = '1;

  bk_state_e           state;
  bk_state_e           state_next;
  job_t                cur;
  logic [COUNT_W-1:0]  mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid;
  logic [COUNT_W-1:0]  rdata;
  logic                rvalid;
  logic                pop_in_range;
  logic [BIN_W-1:0]    rd_addr;
  logic [COUNT_W-1:0]  cur_count;
  logic [COUNT_W-1:0]  new_count;
  logic                we;

  assign pop_in_range = (pop_item.bin < BIN_W'(NUM_BINS));
  assign rd_addr      = pop_in_range ? pop_item.bin : '0;
  assign cur_count    = rvalid ? rdata : '0;
  assign new_count    = (cur_count == CountMax) ? cur_count : cur_count + COUNT_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          state_next = BK_UPD;
        end
      end
      BK_UPD:  state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop              = (state == BK_IDLE) && !q_status.empty;
    done             = (state == BK_UPD);
    we               = done && (cur.op == OP_ACCUM);
    result.bin_index = cur.bin;
    result.bin_count = (cur.op == OP_ACCUM) ? new_count : cur_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      if (we) begin
        valid[cur.bin] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= pop_item;
      rvalid <= pop_in_range && valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[cur.bin] <= new_count;
    end
    rdata <= mem[rd_addr];
  end

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.bin_index >= BIN_W'(NUM_BINS))) |-> (result.bin_count == '0))
    else $error("read of a nonexistent bin returned a nonzero count");

  a_accum_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && (cur.op == OP_ACCUM)) |-> (result.bin_count != '0))
    else $error("accumulate transaction reported a zero count");

endmodule
